// ===== rtl/core/srbm_pkg.sv =====
// Shared types and constants for the semantic-version range best-match core.
// No dependencies; imported by every module under rtl/core.
package srbm_pkg;

  localparam int unsigned FIELD_BITS_DEF = 16;
  localparam int unsigned MAX_TAGS_DEF   = 1024;

  // Range kinds as written to the range_kind register; other codes never match.
  typedef enum logic [2:0] {
    KIND_EXACT = 3'd0,
    KIND_ATLEAST = 3'd1,
    KIND_CARET = 3'd2,
    KIND_TILDE = 3'd3,
    KIND_NEVER = 3'd4
  } range_kind_e;

  // Register word indexes on the APB port.
  typedef enum logic [1:0] {
    REG_RANGE_KIND = 2'd0,
    REG_BASE_MAJOR = 2'd1,
    REG_BASE_MINOR = 2'd2,
    REG_BASE_PATCH = 2'd3
  } reg_idx_e;

  // Tag parser phase, one-hot.
  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_GT     = 5'b00010,
    PH_SKIP   = 5'b00100,
    PH_FIRST  = 5'b01000,
    PH_DIGITS = 5'b10000
  } phase_e;

  // Control bits of one parser record handed to the matcher.
  typedef struct packed {
    logic tag_end;   // record closes a tag: a result is due
    logic list_clr;  // byte opened a new list: drop the best entry
    logic ver_ok;    // closed tag parsed as a version
  } tag_ctrl_t;

endpackage

// ===== rtl/core/srbm_parser.sv =====
// Byte-wise version tag parser with the tag counter and a registered record.
// Depends on srbm_pkg.
module srbm_parser import srbm_pkg::*; #(
  parameter int unsigned FIELD_BITS = FIELD_BITS_DEF,
  parameter int unsigned MAX_TAGS   = MAX_TAGS_DEF,
  localparam int unsigned TagW      = $clog2(MAX_TAGS),
  localparam int unsigned VerW      = 3 * FIELD_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      ch_i,
  input  logic            tag_end_i,
  input  logic            list_start_i,
  output logic            rec_valid_o,
  input  logic            rec_ready_i,
  output tag_ctrl_t       rec_ctrl_o,
  output logic [TagW-1:0] rec_number_o,
  output logic [VerW-1:0] rec_ver_o     // {major, minor, patch}
);

  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChTilde = 8'h7E;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChLowV  = 8'h76;
  localparam logic [7:0] ChUpV   = 8'h56;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [TagW-1:0] TagLast = TagW'(MAX_TAGS - 1);

  phase_e                     phase_q, phase_d, ph_w;
  logic [1:0]                 fsel_q, fsel_d, fsel_w;
  logic [FIELD_BITS-1:0]      acc_q, acc_d, acc_w;
  logic [2:0][FIELD_BITS-1:0] fld_q, fld_d, fld_w;
  logic                       stop_q, stop_d, stop_w;
  logic                       fail_q, fail_d, fail_w;
  logic [TagW-1:0]            cnt_q, cnt_d, cnt_w;

  logic                  take;
  logic                  is_digit, is_skip, fof, ok;
  logic [FIELD_BITS-1:0] dval;
  logic [FIELD_BITS+3:0] prod;
  logic [1:0]            fsel_inc;

  logic            rec_valid_q, rec_valid_d;
  tag_ctrl_t       rec_ctrl_q, rec_ctrl_d;
  logic [TagW-1:0] rec_number_q, rec_number_d;
  logic [VerW-1:0] rec_ver_q, rec_ver_d;

  assign in_ready_o = !rec_valid_q || rec_ready_i;
  assign take       = in_valid_i && in_ready_o;

  assign is_digit = (ch_i >= ChZero) && (ch_i <= ChNine);
  assign is_skip  = (ch_i == ChSpace) || (ch_i == ChLowV) || (ch_i == ChUpV);
  assign dval     = FIELD_BITS'(ch_i[3:0]);
  // acc * 10 + digit, one bit-growth check for saturation
  assign prod     = ({4'b0, acc_w} << 3) + ({4'b0, acc_w} << 1) + {4'b0, dval};
  assign fsel_inc = fsel_w + 2'd1;

  always_comb begin
    // list start opens a fresh parse and a fresh count
    if (list_start_i) begin
      ph_w   = PH_START;
      fsel_w = '0;
      acc_w  = '0;
      fld_w  = '0;
      stop_w = 1'b0;
      fail_w = 1'b0;
      cnt_w  = '0;
    end else begin
      ph_w   = phase_q;
      fsel_w = fsel_q;
      acc_w  = acc_q;
      fld_w  = fld_q;
      stop_w = stop_q;
      fail_w = fail_q;
      cnt_w  = cnt_q;
    end

    phase_d = ph_w;
    fsel_d  = fsel_w;
    acc_d   = acc_w;
    fld_d   = fld_w;
    stop_d  = stop_w;
    fail_d  = fail_w;
    fof     = 1'b0;

    if (!(stop_w || fail_w)) begin
      unique case (ph_w)
        PH_START: begin
          if ((ch_i == ChCaret) || (ch_i == ChTilde)) begin
            phase_d = PH_SKIP;
          end else if (ch_i == ChGt) begin
            phase_d = PH_GT;
          end else if (is_skip) begin
            phase_d = PH_SKIP;
          end else begin
            fof = 1'b1;
          end
        end
        PH_SKIP: begin
          if (!is_skip) fof = 1'b1;
        end
        PH_GT: begin
          if (ch_i == ChEq) phase_d = PH_SKIP;
          else fail_d = 1'b1;
        end
        PH_FIRST: begin
          fof = 1'b1;
        end
        PH_DIGITS: begin
          if (is_digit) begin
            acc_d = (prod[FIELD_BITS+3:FIELD_BITS] != 4'd0) ? '1 : prod[FIELD_BITS-1:0];
          end else begin
            if (fsel_w != 2'd3) fld_d[fsel_w] = acc_w;
            acc_d = '0;
            if (ch_i == ChDot) begin
              fsel_d = fsel_inc;
              if (fsel_inc == 2'd3) stop_d = 1'b1;
              else phase_d = PH_FIRST;
            end else begin
              stop_d = 1'b1;
            end
          end
        end
        default: phase_d = PH_START;
      endcase

      // first byte of a field
      if (fof) begin
        phase_d = PH_FIRST;
        if (is_digit) begin
          acc_d   = dval;
          phase_d = PH_DIGITS;
        end else if (fsel_w == 2'd0) begin
          fail_d = 1'b1;
        end else begin
          stop_d = 1'b1;
        end
      end
    end

    // close the tag on its last byte
    ok = !fail_d && (stop_d || (phase_d == PH_DIGITS) ||
                     ((phase_d == PH_FIRST) && (fsel_d != 2'd0)));
    rec_ver_d = '0;
    if (ok) begin
      rec_ver_d = {fld_d[0], fld_d[1], fld_d[2]};
      if (!stop_d && (phase_d == PH_DIGITS)) begin
        case (fsel_d)
          2'd0:    rec_ver_d[VerW-1 -: FIELD_BITS]            = acc_d;
          2'd1:    rec_ver_d[2*FIELD_BITS-1 -: FIELD_BITS]    = acc_d;
          2'd2:    rec_ver_d[FIELD_BITS-1:0]                  = acc_d;
          default: rec_ver_d = rec_ver_d;
        endcase
      end
    end
    rec_ctrl_d   = '{tag_end: tag_end_i, list_clr: list_start_i, ver_ok: ok};
    rec_number_d = cnt_w;

    cnt_d = cnt_w;
    if (tag_end_i) begin
      phase_d = PH_START;
      fsel_d  = '0;
      acc_d   = '0;
      fld_d   = '0;
      stop_d  = 1'b0;
      fail_d  = 1'b0;
      cnt_d   = (cnt_w == TagLast) ? '0 : cnt_w + TagW'(1);
    end
  end

  assign rec_valid_d = take ? 1'b1 : (rec_ready_i ? 1'b0 : rec_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      fsel_q      <= '0;
      acc_q       <= '0;
      fld_q       <= '0;
      stop_q      <= 1'b0;
      fail_q      <= 1'b0;
      cnt_q       <= '0;
      rec_valid_q <= 1'b0;
    end else begin
      rec_valid_q <= rec_valid_d;
      if (take) begin
        phase_q <= phase_d;
        fsel_q  <= fsel_d;
        acc_q   <= acc_d;
        fld_q   <= fld_d;
        stop_q  <= stop_d;
        fail_q  <= fail_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rec_ctrl_q   <= rec_ctrl_d;
      rec_number_q <= rec_number_d;
      rec_ver_q    <= rec_ver_d;
    end
  end

  assign rec_valid_o  = rec_valid_q;
  assign rec_ctrl_o   = rec_ctrl_q;
  assign rec_number_o = rec_number_q;
  assign rec_ver_o    = rec_ver_q;

endmodule

// ===== rtl/core/srbm_matcher.sv =====
// Range test, best-tag tracking and the result register.
// Depends on srbm_pkg.
module srbm_matcher import srbm_pkg::*; #(
  parameter int unsigned FIELD_BITS = FIELD_BITS_DEF,
  parameter int unsigned MAX_TAGS   = MAX_TAGS_DEF,
  localparam int unsigned TagW      = $clog2(MAX_TAGS),
  localparam int unsigned VerW      = 3 * FIELD_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [2:0]      range_kind_i,
  input  logic [VerW-1:0] base_ver_i,    // {major, minor, patch}
  input  logic            rec_valid_i,
  output logic            rec_ready_o,
  input  tag_ctrl_t       rec_ctrl_i,
  input  logic [TagW-1:0] rec_number_i,
  input  logic [VerW-1:0] rec_ver_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output logic [TagW-1:0] tag_number_o,
  output logic            tag_valid_o,
  output logic [VerW-1:0] tag_ver_o,
  output logic            tag_matches_o,
  output logic            best_found_o,
  output logic [TagW-1:0] best_number_o,
  output logic [VerW-1:0] best_ver_o
);

  logic                  take;
  logic [FIELD_BITS-1:0] v_maj, v_min, v_pat, b_maj, b_min, b_pat;
  logic                  ge_base, in_range, match, upd;

  logic            best_valid_q, best_valid_w, best_valid_d;
  logic [TagW-1:0] best_pos_q, best_pos_w, best_pos_d;
  logic [VerW-1:0] best_ver_q, best_ver_w, best_ver_d;

  logic            res_valid_q, res_valid_d;
  logic [TagW-1:0] tag_number_q;
  logic            tag_valid_q, tag_matches_q, best_found_q;
  logic [VerW-1:0] tag_ver_q, best_ver_out_q;
  logic [TagW-1:0] best_number_q;

  // records that close no tag never wait on the result register
  assign rec_ready_o = !res_valid_q || res_ready_i || !rec_ctrl_i.tag_end;
  assign take        = rec_valid_i && rec_ready_o;

  assign {v_maj, v_min, v_pat} = rec_ver_i;
  assign {b_maj, b_min, b_pat} = base_ver_i;

  // {major, minor, patch} packed major-high compares in version order
  assign ge_base = (rec_ver_i >= base_ver_i);

  always_comb begin
    case (range_kind_i)
      KIND_EXACT:   in_range = (rec_ver_i == base_ver_i);
      KIND_ATLEAST: in_range = ge_base;
      KIND_CARET: begin
        // below the next major, else next minor, else next patch
        if (b_maj != '0)      in_range = ge_base && (v_maj <= b_maj);
        else if (b_min != '0) in_range = ge_base && (v_maj == '0) && (v_min <= b_min);
        else                  in_range = ge_base && (v_maj == '0) && (v_min == '0) &&
                                         (v_pat <= b_pat);
      end
      KIND_TILDE:   in_range = ge_base &&
                               ((v_maj < b_maj) || ((v_maj == b_maj) && (v_min <= b_min)));
      default:      in_range = 1'b0;
    endcase
  end

  always_comb begin
    best_valid_w = rec_ctrl_i.list_clr ? 1'b0 : best_valid_q;
    best_pos_w   = rec_ctrl_i.list_clr ? '0   : best_pos_q;
    best_ver_w   = rec_ctrl_i.list_clr ? '0   : best_ver_q;

    match = rec_ctrl_i.ver_ok && in_range;
    // strict greater keeps the first of equal versions
    upd   = rec_ctrl_i.tag_end && match && (!best_valid_w || (rec_ver_i > best_ver_w));

    best_valid_d = upd ? 1'b1         : best_valid_w;
    best_pos_d   = upd ? rec_number_i : best_pos_w;
    best_ver_d   = upd ? rec_ver_i    : best_ver_w;
  end

  assign res_valid_d = (res_valid_q && !res_ready_i) || (take && rec_ctrl_i.tag_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_valid_q <= 1'b0;
      best_pos_q   <= '0;
      best_ver_q   <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (take) begin
        best_valid_q <= best_valid_d;
        best_pos_q   <= best_pos_d;
        best_ver_q   <= best_ver_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && rec_ctrl_i.tag_end) begin
      tag_number_q   <= rec_number_i;
      tag_valid_q    <= rec_ctrl_i.ver_ok;
      tag_ver_q      <= rec_ver_i;
      tag_matches_q  <= match;
      best_found_q   <= best_valid_d;
      best_number_q  <= best_pos_d;
      best_ver_out_q <= best_ver_d;
    end
  end

  assign res_valid_o   = res_valid_q;
  assign tag_number_o  = tag_number_q;
  assign tag_valid_o   = tag_valid_q;
  assign tag_ver_o     = tag_ver_q;
  assign tag_matches_o = tag_matches_q;
  assign best_found_o  = best_found_q;
  assign best_number_o = best_number_q;
  assign best_ver_o    = best_ver_out_q;

endmodule

// ===== rtl/core/semver_range_best_match_core.sv =====
// Top level of the semantic-version range best-match core: APB registers,
// input stage, parser and matcher. Depends on srbm_pkg, srbm_parser, srbm_matcher.
//
// Version tags stream in one byte per item on the slave stream, tlast on the
// last byte of a tag and tuser on the first byte of a new list. Each tag may
// carry one leading "^", "~" or ">=", then spaces or v/V, then up to three
// dot-separated decimal fields (missing minor/patch read as zero, each
// field saturates at all ones). At the end of every tag one result item
// comes out: the tag's position, whether it parsed, its fields, whether it
// falls in the programmed range, and the first-seen highest matching tag of
// the list so far. Throughput is one byte per clock sustained while the
// result side is ready. The last byte of a tag passes through the input
// register, then the parser record register, and m_axis_tvalid rises when
// it loads the result register. The rate is set by the parser state
// register, which takes one byte per cycle through a single multiply-by-ten
// accumulate. While a result waits, bytes keep flowing until the next tag's
// last byte reaches the matcher; that byte then holds in the parser record,
// one more byte is taken into the input register, and the input stalls
// until the result leaves. Program range_kind and the base version over APB
// while the stream is idle; range_kind resets to "never".
module semver_range_best_match_core import srbm_pkg::*; #(
  parameter int unsigned FIELD_BITS = FIELD_BITS_DEF,
  parameter int unsigned MAX_TAGS   = MAX_TAGS_DEF,
  localparam int unsigned TagW      = $clog2(MAX_TAGS),
  localparam int unsigned VerW      = 3 * FIELD_BITS,
  localparam int unsigned OutRaw    = 2 * TagW + 2 * VerW + 3,
  localparam int unsigned OutW      = ((OutRaw + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // APB register port
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  // tag bytes in
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // [7:0] ch
  input  logic            s_axis_tlast,   // tag_end
  input  logic            s_axis_tuser,   // list_start
  // results out
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata    // low to high: tag_number, tag_valid,
                                          // tag_major, tag_minor, tag_patch,
                                          // tag_matches, best_found, best_number,
                                          // best_major, best_minor, best_patch, zero pad
);

  // ---------------- configuration registers ----------------
  logic [2:0]            range_kind_q;
  logic [FIELD_BITS-1:0] base_major_q, base_minor_q, base_patch_q;
  logic                  cfg_wr;
  reg_idx_e              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_kind_q <= KIND_NEVER;
      base_major_q <= '0;
      base_minor_q <= '0;
      base_patch_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_RANGE_KIND: range_kind_q <= pwdata[2:0];
        REG_BASE_MAJOR: base_major_q <= pwdata[FIELD_BITS-1:0];
        REG_BASE_MINOR: base_minor_q <= pwdata[FIELD_BITS-1:0];
        REG_BASE_PATCH: base_patch_q <= pwdata[FIELD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_RANGE_KIND: prdata = 32'(range_kind_q);
      REG_BASE_MAJOR: prdata = 32'(base_major_q);
      REG_BASE_MINOR: prdata = 32'(base_minor_q);
      REG_BASE_PATCH: prdata = 32'(base_patch_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_ch_q;
  logic       in_end_q, in_start_q;
  logic       par_ready, in_take;

  assign s_axis_tready = !in_valid_q || par_ready;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = in_take ? 1'b1 : (par_ready ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_valid_q <= 1'b0;
    else         in_valid_q <= in_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_ch_q    <= s_axis_tdata;
      in_end_q   <= s_axis_tlast;
      in_start_q <= s_axis_tuser;
    end
  end

  // ---------------- parser ----------------
  logic            rec_valid, rec_ready;
  tag_ctrl_t       rec_ctrl;
  logic [TagW-1:0] rec_number;
  logic [VerW-1:0] rec_ver;

  srbm_parser #(
    .FIELD_BITS(FIELD_BITS),
    .MAX_TAGS  (MAX_TAGS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .in_ready_o  (par_ready),
    .ch_i        (in_ch_q),
    .tag_end_i   (in_end_q),
    .list_start_i(in_start_q),
    .rec_valid_o (rec_valid),
    .rec_ready_i (rec_ready),
    .rec_ctrl_o  (rec_ctrl),
    .rec_number_o(rec_number),
    .rec_ver_o   (rec_ver)
  );

  // ---------------- matcher and result register ----------------
  logic [TagW-1:0] tag_number, best_number;
  logic            tag_valid, tag_matches, best_found;
  logic [VerW-1:0] tag_ver, best_ver;

  srbm_matcher #(
    .FIELD_BITS(FIELD_BITS),
    .MAX_TAGS  (MAX_TAGS)
  ) u_matcher (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .range_kind_i (range_kind_q),
    .base_ver_i   ({base_major_q, base_minor_q, base_patch_q}),
    .rec_valid_i  (rec_valid),
    .rec_ready_o  (rec_ready),
    .rec_ctrl_i   (rec_ctrl),
    .rec_number_i (rec_number),
    .rec_ver_i    (rec_ver),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .tag_number_o (tag_number),
    .tag_valid_o  (tag_valid),
    .tag_ver_o    (tag_ver),
    .tag_matches_o(tag_matches),
    .best_found_o (best_found),
    .best_number_o(best_number),
    .best_ver_o   (best_ver)
  );

  // versions travel {major, minor, patch}; tdata wants major lowest
  logic [FIELD_BITS-1:0] t_maj, t_min, t_pat, b_maj, b_min, b_pat;
  logic [OutRaw-1:0]     out_raw;

  assign {t_maj, t_min, t_pat} = tag_ver;
  assign {b_maj, b_min, b_pat} = best_ver;
  assign out_raw = {b_pat, b_min, b_maj, best_number, best_found, tag_matches,
                    t_pat, t_min, t_maj, tag_valid, tag_number};
  assign m_axis_tdata = OutW'(out_raw);

endmodule
